[rtl/csrgt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrgt_pkg
// Shared constants, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package csrgt_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 4096;

   localparam int VID_W   = 10;   // vertex id
   localparam int CNT_W   = 13;   // edge counts, offsets, indexes
   localparam int NCFG_W  = 11;   // vertex count register
   localparam int EADDR_W = 12;   // edge store address
   localparam int OADDR_W = 11;   // offset store address
   localparam int MODE_W  = 3;
   localparam int STS_W   = 3;

   localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BUILD    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RD_OFFS  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RD_LIST  = 3'd4;

   localparam logic [STS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STS_W-1:0] ST_FULL   = 3'd1;
   localparam logic [STS_W-1:0] ST_BAD_ID = 3'd2;
   localparam logic [STS_W-1:0] ST_ORDER  = 3'd3;
   localparam logic [STS_W-1:0] ST_PHASE  = 3'd4;
   localparam logic [STS_W-1:0] ST_INDEX  = 3'd5;

   typedef struct packed {
      logic take;
      logic exec_clear;
      logic add_rd;
      logic add_wr;
      logic rd_issue;
      logic bld_fail;
      logic pre_init;
      logic pre_rd;
      logic pre_wr;
      logic sc_init;
      logic sc_rd_edge;
      logic sc_rd_cur;
      logic sc_wr;
      logic bld_done;
      logic finish;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              sts_ok;
      logic              pre_done;
      logic              sc_done;
      logic              clr_last;
      logic              rsp_free;
   } stat_type;

endpackage

[rtl/csrgt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrgt channel interfaces
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface csrgt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [9:0]  source_id;
   logic [9:0]  target_id;
   logic [12:0] read_index;

   modport source (output valid, mode, source_id, target_id, read_index, input ready);
   modport sink   (input valid, mode, source_id, target_id, read_index, output ready);
endinterface

interface csrgt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [12:0] read_value;

   modport source (output valid, status, read_value, input ready);
   modport sink   (input valid, status, read_value, output ready);
endinterface

[rtl/csrgt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrgt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csrgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/csrgt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrgt_ctrl
// Sequencer for command execution, build passes and degree clearing.
// ----------------------------------------------------------------------------
module csrgt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  csrgt_pkg::stat_type stat,
   output csrgt_pkg::cmd_type  cmd
);
   import csrgt_pkg::*;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_ADD_WR = 4'd3;
   localparam logic [3:0] S_PRE_RD = 4'd4;
   localparam logic [3:0] S_PRE_WR = 4'd5;
   localparam logic [3:0] S_SC_E   = 4'd6;
   localparam logic [3:0] S_SC_C   = 4'd7;
   localparam logic [3:0] S_SC_W   = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            unique case (stat.mode)
               MODE_CLEAR: cmd.exec_clear = 1'b1;
               MODE_ADD: begin
                  if (stat.sts_ok) begin
                     cmd.add_rd = 1'b1;
                     state_in   = S_ADD_WR;
                  end
               end
               MODE_BUILD: begin
                  if (stat.sts_ok) begin
                     cmd.pre_init = 1'b1;
                     state_in     = S_PRE_RD;
                  end else begin
                     cmd.bld_fail = 1'b1;
                  end
               end
               MODE_RD_OFFS, MODE_RD_LIST: cmd.rd_issue = stat.sts_ok;
               default: ;
            endcase
         end
         S_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = S_FIN;
         end
         S_PRE_RD: begin
            if (stat.pre_done) begin
               cmd.sc_init = 1'b1;
               state_in    = S_SC_E;
            end else begin
               cmd.pre_rd = 1'b1;
               state_in   = S_PRE_WR;
            end
         end
         S_PRE_WR: begin
            cmd.pre_wr = 1'b1;
            state_in   = S_PRE_RD;
         end
         S_SC_E: begin
            if (stat.sc_done) begin
               cmd.bld_done = 1'b1;
               state_in     = S_FIN;
            end else begin
               cmd.sc_rd_edge = 1'b1;
               state_in       = S_SC_C;
            end
         end
         S_SC_C: begin
            cmd.sc_rd_cur = 1'b1;
            state_in      = S_SC_W;
         end
         S_SC_W: begin
            cmd.sc_wr = 1'b1;
            state_in  = S_SC_E;
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = (stat.mode == MODE_CLEAR) ? S_CLR : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[rtl/csrgt_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrgt_dpath
// Edge, degree, offset, cursor and list stores with their counters.
// ----------------------------------------------------------------------------
module csrgt_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  csrgt_pkg::cmd_type                 cmd,
   output csrgt_pkg::stat_type                stat,
   input  logic                               csr_wr_en,
   input  logic [csrgt_pkg::NCFG_W-1:0]       csr_wr_data,
   input  logic [csrgt_pkg::MODE_W-1:0]       req_mode,
   input  logic [csrgt_pkg::VID_W-1:0]        req_source_id,
   input  logic [csrgt_pkg::VID_W-1:0]        req_target_id,
   input  logic [csrgt_pkg::CNT_W-1:0]        req_read_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [csrgt_pkg::STS_W-1:0]        rsp_status,
   output logic [csrgt_pkg::CNT_W-1:0]        rsp_read_value
);
   import csrgt_pkg::*;

   logic [NCFG_W-1:0] ncfg_ff;
   logic [NCFG_W-1:0] nuse;
   logic [MODE_W-1:0] mode_ff;
   logic [VID_W-1:0]  src_ff, dst_ff;
   logic [CNT_W-1:0]  ridx_ff;
   logic [STS_W-1:0]  sts_ff, sts_in;
   logic [CNT_W-1:0]  ecnt_ff;
   logic [VID_W-1:0]  last_src_ff, max_dst_ff;
   logic              built_ff;
   logic [NCFG_W-1:0] bverts_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  acc_ff;
   logic              rsp_valid_ff;
   logic [STS_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]  rsp_value_ff;
   logic [CNT_W-1:0]  res_value;

   logic [CNT_W-1:0]          deg_rd, off_rd, cur_rd;
   logic [2*VID_W-1:0]        edge_rd;
   logic [VID_W-1:0]          list_rd;
   logic [VID_W-1:0]          e_src, e_dst;
   logic [CNT_W-1:0]          deg_sum;

   // Vertices in use: the register capped at the store size.
   assign nuse = (ncfg_ff < NCFG_W'(MAX_VERTICES)) ? ncfg_ff : NCFG_W'(MAX_VERTICES);
   assign e_src = edge_rd[2*VID_W-1:VID_W];
   assign e_dst = edge_rd[VID_W-1:0];
   assign deg_sum = acc_ff + deg_rd;

   always_comb begin
      unique case (req_mode)
         MODE_CLEAR: sts_in = ST_OK;
         MODE_ADD: begin
            priority if (built_ff) sts_in = ST_PHASE;
            else if ({1'b0, req_source_id} >= nuse || {1'b0, req_target_id} >= nuse)
               sts_in = ST_BAD_ID;
            else if (req_source_id < last_src_ff) sts_in = ST_ORDER;
            else if (ecnt_ff >= CNT_W'(MAX_EDGES)) sts_in = ST_FULL;
            else sts_in = ST_OK;
         end
         MODE_BUILD: begin
            if (ecnt_ff != '0 && ({1'b0, last_src_ff} >= nuse || {1'b0, max_dst_ff} >= nuse))
               sts_in = ST_BAD_ID;
            else
               sts_in = ST_OK;
         end
         MODE_RD_OFFS: begin
            priority if (!built_ff) sts_in = ST_PHASE;
            else if (req_read_index > CNT_W'(bverts_ff)) sts_in = ST_INDEX;
            else sts_in = ST_OK;
         end
         MODE_RD_LIST: begin
            priority if (!built_ff) sts_in = ST_PHASE;
            else if (req_read_index >= ecnt_ff) sts_in = ST_INDEX;
            else sts_in = ST_OK;
         end
         default: sts_in = ST_PHASE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff <= req_mode;
         src_ff  <= req_source_id;
         dst_ff  <= req_target_id;
         ridx_ff <= req_read_index;
         sts_ff  <= sts_in;
      end
      if (cmd.pre_init) begin
         acc_ff <= '0;
      end else if (cmd.pre_wr) begin
         acc_ff <= deg_sum;
      end
      if (cmd.finish) begin
         rsp_status_ff <= sts_ff;
         rsp_value_ff  <= res_value;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.exec_clear || cmd.pre_init || cmd.sc_init) begin
         idx_in = '0;
      end else if (cmd.clr_step || cmd.pre_wr || cmd.sc_wr) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncfg_ff      <= NCFG_W'(1);
         ecnt_ff      <= '0;
         last_src_ff  <= '0;
         max_dst_ff   <= '0;
         built_ff     <= 1'b0;
         bverts_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (csr_wr_en) begin
            ncfg_ff <= csr_wr_data;
         end
         if (cmd.exec_clear) begin
            ecnt_ff     <= '0;
            last_src_ff <= '0;
            max_dst_ff  <= '0;
            built_ff    <= 1'b0;
            bverts_ff   <= '0;
         end
         if (cmd.add_wr) begin
            ecnt_ff     <= ecnt_ff + CNT_W'(1);
            last_src_ff <= src_ff;
            if (dst_ff > max_dst_ff) begin
               max_dst_ff <= dst_ff;
            end
         end
         if (cmd.bld_fail) begin
            built_ff <= 1'b0;
         end
         if (cmd.bld_done) begin
            built_ff  <= 1'b1;
            bverts_ff <= nuse;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      res_value = '0;
      unique case (mode_ff)
         MODE_ADD, MODE_BUILD: res_value = ecnt_ff;
         MODE_RD_OFFS: if (sts_ff == ST_OK) res_value = off_rd;
         MODE_RD_LIST: if (sts_ff == ST_OK) res_value = CNT_W'(list_rd);
         default: res_value = '0;
      endcase
   end

   // In-degree counts, zeroed by the sweep after reset and after clear.
   csrgt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_deg (
      .clock   (clock),
      .wr_en   (cmd.clr_step || cmd.add_wr),
      .wr_addr (cmd.clr_step ? idx_ff[VID_W-1:0] : dst_ff),
      .wr_data (cmd.clr_step ? '0 : deg_rd + CNT_W'(1)),
      .rd_en   (cmd.add_rd || cmd.pre_rd),
      .rd_addr (cmd.pre_rd ? idx_ff[VID_W-1:0] : dst_ff),
      .rd_data (deg_rd)
   );

   csrgt_ram #(.WIDTH(2*VID_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock   (clock),
      .wr_en   (cmd.add_rd),
      .wr_addr (ecnt_ff[EADDR_W-1:0]),
      .wr_data ({src_ff, dst_ff}),
      .rd_en   (cmd.sc_rd_edge),
      .rd_addr (idx_ff[EADDR_W-1:0]),
      .rd_data (edge_rd)
   );

   csrgt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES + 1)) u_offs (
      .clock   (clock),
      .wr_en   (cmd.pre_init || cmd.pre_wr),
      .wr_addr (cmd.pre_init ? '0 : idx_ff[OADDR_W-1:0] + OADDR_W'(1)),
      .wr_data (cmd.pre_init ? '0 : deg_sum),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ridx_ff[OADDR_W-1:0]),
      .rd_data (off_rd)
   );

   csrgt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_cur (
      .clock   (clock),
      .wr_en   (cmd.pre_wr || cmd.sc_wr),
      .wr_addr (cmd.pre_wr ? idx_ff[VID_W-1:0] : e_dst),
      .wr_data (cmd.pre_wr ? acc_ff : cur_rd + CNT_W'(1)),
      .rd_en   (cmd.sc_rd_cur),
      .rd_addr (e_dst),
      .rd_data (cur_rd)
   );

   csrgt_ram #(.WIDTH(VID_W), .DEPTH(MAX_EDGES)) u_list (
      .clock   (clock),
      .wr_en   (cmd.sc_wr && (cur_rd < CNT_W'(MAX_EDGES))),
      .wr_addr (cur_rd[EADDR_W-1:0]),
      .wr_data (e_src),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ridx_ff[EADDR_W-1:0]),
      .rd_data (list_rd)
   );

   assign stat.mode     = mode_ff;
   assign stat.sts_ok   = (sts_ff == ST_OK);
   assign stat.pre_done = (idx_ff == CNT_W'(nuse));
   assign stat.sc_done  = (idx_ff == ecnt_ff);
   assign stat.clr_last = (idx_ff[VID_W-1:0] == VID_W'(MAX_VERTICES - 1));
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
endmodule

[rtl/csr_graph_transpose.sv]
`timescale 1ns / 1ps
// One command is handled at a time; the next is accepted once the result is registered.
// After reset and after each clear the degree store is swept, during which no command
// is accepted. On reset the vertex count register resets to 1.
// ----------------------------------------------------------------------------
// csr_graph_transpose
// Builds the predecessor CSR form of a directed graph from a stream of edges.
// ----------------------------------------------------------------------------
module csr_graph_transpose (
   input  logic                          clock,
   input  logic                          reset,
   csrgt_req_if.sink                     req_chan,
   csrgt_rsp_if.source                   rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [csrgt_pkg::NCFG_W-1:0]  csr_wr_data
);
   import csrgt_pkg::*;

   // The controller steps through each command: capture, an execute state
   // that checks the precomputed status, the memory passes of add or build,
   // and a finish state that loads the result register once it is free. The
   // result register holds each transfer until the sink takes it.
   cmd_type  cmd;
   stat_type stat;

   csrgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds all stores; build runs a prefix-sum pass over the
   // degree counts and then a scatter pass over the stored edges.
   csrgt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_mode       (req_chan.mode),
      .req_source_id  (req_chan.source_id),
      .req_target_id  (req_chan.target_id),
      .req_read_index (req_chan.read_index),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_status     (rsp_chan.status),
      .rsp_read_value (rsp_chan.read_value)
   );
endmodule
